// ===== src/mi4_pkg.sv =====
// mi4_pkg: shared types, constants and fixed-point helpers for the 4x4 inverse.
// No dependencies; imported by matrix_inverse_4x4 and mi4_mac.
package mi4_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int RECIP_BITS    = 62;
  localparam int ELEM_W        = 32;
  localparam int COF_W         = 64;
  localparam int ACC_W         = 128;
  localparam int MAT_DEPTH     = 16;

  // accumulator result destinations
  localparam logic [2:0] DST_M0  = 3'd0;
  localparam logic [2:0] DST_M1  = 3'd1;
  localparam logic [2:0] DST_M2  = 3'd2;
  localparam logic [2:0] DST_COF = 3'd3;
  localparam logic [2:0] DST_DET = 3'd4;
  localparam logic [2:0] DST_OUT = 3'd5;

  typedef struct packed {
    logic [2:0] dst;
    logic [3:0] idx;
  } tag_t;

  typedef struct packed {
    logic       issue;
    logic       first;
    logic       last;
    logic [1:0] shift;
    logic       neg;
    tag_t       tag;
  } mac_ctl_t;

  typedef struct packed {
    logic        clip;
    logic [63:0] val;
  } sat64_t;

  // n-th remaining row/column index after removing x
  function automatic logic [1:0] others_idx(input logic [1:0] x, input logic [1:0] n);
    return (n >= x) ? n + 2'd1 : n;
  endfunction

  // add half an LSB of the target, then arithmetic shift right
  function automatic logic signed [ACC_W-1:0] round_shift(input logic signed [ACC_W-1:0] a,
                                                          input int s);
    logic signed [ACC_W-1:0] t;
    t = a + (ACC_W'(1) << (s - 1));
    return t >>> s;
  endfunction

  function automatic sat64_t sat64(input logic signed [ACC_W-1:0] a);
    sat64_t r;
    r.clip = (a[ACC_W-1:64] != {64{a[63]}});
    if (r.clip) begin
      r.val = a[ACC_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      r.val = a[63:0];
    end
    return r;
  endfunction

endpackage

// ===== src/matrix_inverse_4x4.sv =====
// matrix_inverse_4x4: 4x4 inverse by adjugate, signed fixed point, one shared multiplier.
// After the sixteenth element is transferred, the block computes the cofactors, the determinant,
// the reciprocal (skipped when the determinant is zero or too large) and then the results, one
// at a time from the shared MAC; a new matrix can be loaded only once the last result is done.
// Synchronous active-low reset returns to the load state with the element count at zero.
// Results cannot be stalled: each one is valid for exactly one cycle.
module matrix_inverse_4x4 import mi4_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] in_element,
  output logic               busy,
  output logic               out_valid,
  output logic signed [31:0] out_inv_element,
  output logic [3:0]         out_index,
  output logic               out_last_of_run,
  output logic               out_singular,
  output logic               out_saturated
);

  localparam int COF_SHIFT = 2 * FRAC_BITS;
  localparam int OUT_SHIFT = RECIP_BITS - 2 * FRAC_BITS;

  // sequencer states
  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_PF    = 3'd1;  // issue RAM reads for one product
  localparam logic [2:0] ST_PS    = 3'd2;  // latch operand magnitudes and sign
  localparam logic [2:0] ST_PM    = 3'd3;  // feed 32x32 partial products
  localparam logic [2:0] ST_DWAIT = 3'd4;
  localparam logic [2:0] ST_DCHK  = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_OWAIT = 3'd7;

  // computation phases
  localparam logic [1:0] PH_COF = 2'd0;
  localparam logic [1:0] PH_DET = 2'd1;
  localparam logic [1:0] PH_OUT = 2'd2;

  // operand sources
  localparam logic       SRC_A_MAT  = 1'b0;
  localparam logic       SRC_A_COF  = 1'b1;
  localparam logic [1:0] SRC_B_MAT  = 2'd0;
  localparam logic [1:0] SRC_B_MREG = 2'd1;
  localparam logic [1:0] SRC_B_COF  = 2'd2;
  localparam logic [1:0] SRC_B_RREG = 2'd3;

  // control registers
  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] k_r, k_nxt;          // cofactor / output index
  logic [3:0] op_r, op_nxt;        // product step within a group run
  logic [1:0] pc_r, pc_nxt;        // partial-product counter
  logic [3:0] load_cnt_r, load_cnt_nxt;

  // datapath registers
  logic [63:0]             mag_a_r, mag_b_r;
  logic                    neg_r, a_wide_r, b_wide_r;
  logic signed [63:0]      m_r [3];   // 2x2 minors of the current cofactor
  logic signed [ACC_W-1:0] det_r;
  logic                    dneg_r;
  logic                    singular_r;
  logic signed [63:0]      r_r;       // reciprocal, 1.0 = 2^62

  // output registers
  logic               out_valid_r;
  logic signed [31:0] out_elem_r;
  logic [3:0]         out_idx_r;
  logic               out_last_r, out_sing_r, out_sat_r;

  // RAM ports
  logic [31:0] mat_rd_a, mat_rd_b;
  logic [63:0] cof_rd, cof_rd_b, cof_wdata;
  logic        cof_we;

  // multiplier
  mac_ctl_t                mac_ctl;
  logic                    mac_done;
  tag_t                    mac_tag;
  logic signed [ACC_W-1:0] acc;

  // divider
  logic        div_start, div_done;
  logic [63:0] div_num, div_quo;

  // current product descriptor
  logic [3:0] d_addr_a, d_addr_b, d_cof_addr;
  logic       d_a_src;
  logic [1:0] d_b_src;
  logic       d_neg, d_first, d_last;
  tag_t       d_tag;
  logic [1:0] gm;

  logic [1:0] ci, cj, r0, r1, r2, c0, c1, c2, cp, cq, cg;
  logic [3:0] op_m;

  logic accept;
  logic part_last, ia, ib;

  assign accept = start && (state_r == ST_LOAD);

  // cofactor (i,j) is the minor without row j and column i
  assign ci = k_r[3:2];
  assign cj = k_r[1:0];
  assign r0 = others_idx(cj, 2'd0);
  assign r1 = others_idx(cj, 2'd1);
  assign r2 = others_idx(cj, 2'd2);
  assign c0 = others_idx(ci, 2'd0);
  assign c1 = others_idx(ci, 2'd1);
  assign c2 = others_idx(ci, 2'd2);
  assign op_m = op_r - 4'd6;

  always_comb begin
    case (op_r[2:1])
      2'd0:    begin cp = c1; cq = c2; end
      2'd1:    begin cp = c0; cq = c2; end
      default: begin cp = c0; cq = c1; end
    endcase
    case (op_m[1:0])
      2'd0:    cg = c0;
      2'd1:    cg = c1;
      default: cg = c2;
    endcase
  end

  always_comb begin
    d_addr_a   = '0;
    d_addr_b   = '0;
    d_cof_addr = '0;
    d_a_src    = SRC_A_MAT;
    d_b_src    = SRC_B_MAT;
    d_neg      = 1'b0;
    d_first    = 1'b1;
    d_last     = 1'b1;
    d_tag.dst  = DST_OUT;
    d_tag.idx  = k_r;
    gm         = op_m[1:0];
    case (phase_r)
      PH_COF: begin
        if (op_r < 4'd6) begin
          // minor2 pair: +a*d then -b*c
          d_addr_a = op_r[0] ? {r1, cq} : {r1, cp};
          d_addr_b = op_r[0] ? {r2, cp} : {r2, cq};
          d_neg    = op_r[0];
          d_first  = ~op_r[0];
          d_last   = op_r[0];
          case (op_r[2:1])
            2'd0:    d_tag.dst = DST_M0;
            2'd1:    d_tag.dst = DST_M1;
            default: d_tag.dst = DST_M2;
          endcase
        end else begin
          // top-row expansion; checkerboard sign folded in before rounding
          d_addr_a  = {r0, cg};
          d_b_src   = SRC_B_MREG;
          d_neg     = (gm == 2'd1) ^ k_r[2] ^ k_r[0];
          d_first   = (gm == 2'd0);
          d_last    = (gm == 2'd2);
          d_tag.dst = DST_COF;
        end
      end
      PH_DET: begin
        d_addr_a   = op_r;
        d_cof_addr = {op_r[1:0], 2'b00};
        d_b_src    = SRC_B_COF;
        d_first    = (op_r == 4'd0);
        d_last     = (op_r == 4'd3);
        d_tag.dst  = DST_DET;
      end
      default: begin
        d_cof_addr = k_r;
        d_a_src    = SRC_A_COF;
        d_b_src    = SRC_B_RREG;
      end
    endcase
  end

  mi4_ram #(.WIDTH(ELEM_W), .DEPTH(MAT_DEPTH)) u_mat_ram (
    .clk       (clk),
    .we        (accept),
    .wr_addr   (load_cnt_r),
    .wr_data   (in_element),
    .re        (state_r == ST_PF),
    .rd_addr_a (d_addr_a),
    .rd_addr_b (d_addr_b),
    .rd_data_a (mat_rd_a),
    .rd_data_b (mat_rd_b)
  );

  mi4_ram #(.WIDTH(COF_W), .DEPTH(MAT_DEPTH)) u_cof_ram (
    .clk       (clk),
    .we        (cof_we),
    .wr_addr   (mac_tag.idx),
    .wr_data   (cof_wdata),
    .re        (state_r == ST_PF),
    .rd_addr_a (d_cof_addr),
    .rd_addr_b (d_cof_addr),
    .rd_data_a (cof_rd),
    .rd_data_b (cof_rd_b)
  );

  // operand setup: signed values to magnitude and sign
  logic signed [63:0] va, vb;
  always_comb begin
    va = (d_a_src == SRC_A_COF) ? cof_rd : 64'(signed'(mat_rd_a));
    case (d_b_src)
      SRC_B_MAT:  vb = 64'(signed'(mat_rd_b));
      SRC_B_MREG: vb = m_r[gm];
      SRC_B_COF:  vb = cof_rd_b;
      default:    vb = r_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PS) begin
      mag_a_r  <= va[63] ? -va : va;
      mag_b_r  <= vb[63] ? -vb : vb;
      neg_r    <= va[63] ^ vb[63] ^ d_neg;
      a_wide_r <= (d_a_src == SRC_A_COF);
      b_wide_r <= (d_b_src != SRC_B_MAT);
    end
  end

  // partial products: 1, 2 or 4 depending on operand widths
  assign part_last = a_wide_r ? (pc_r == 2'd3) : (b_wide_r ? (pc_r == 2'd1) : 1'b1);
  assign ia        = a_wide_r & pc_r[1];
  assign ib        = b_wide_r & pc_r[0];

  always_comb begin
    mac_ctl.issue = (state_r == ST_PM);
    mac_ctl.first = d_first && (pc_r == 2'd0);
    mac_ctl.last  = d_last && part_last;
    mac_ctl.shift = {1'b0, ia} + {1'b0, ib};
    mac_ctl.neg   = neg_r;
    mac_ctl.tag   = d_tag;
  end

  mi4_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .a_part   (ia ? mag_a_r[63:32] : mag_a_r[31:0]),
    .b_part   (ib ? mag_b_r[63:32] : mag_b_r[31:0]),
    .done     (mac_done),
    .done_tag (mac_tag),
    .acc      (acc)
  );

  // determinant check and reciprocal numerator
  logic signed [ACC_W-1:0] det_mag;
  logic                    det_zero, det_small;
  assign det_mag   = det_r[ACC_W-1] ? -det_r : det_r;
  assign det_zero  = (det_r == '0);
  assign det_small = (det_mag[ACC_W-1:64] == '0) &&
                     (det_mag[63:0] <= 64'h8000_0000_0000_0000);
  assign div_start = (state_r == ST_DCHK) && !det_zero && det_small;
  assign div_num   = (64'd1 << RECIP_BITS) + {1'b0, det_mag[63:1]};

  mi4_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (det_mag[63:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // result capture: cofactor rounding, output rounding and saturation
  logic signed [ACC_W-1:0] cof_rnd, out_rnd;
  sat64_t                  c64, o64;
  logic                    fits32;
  logic signed [31:0]      e32;

  assign cof_rnd   = round_shift(acc, COF_SHIFT);
  assign c64       = sat64(cof_rnd);
  assign cof_wdata = c64.val;
  assign cof_we    = mac_done && (mac_tag.dst == DST_COF);

  assign out_rnd = round_shift(acc, OUT_SHIFT);
  assign o64     = sat64(out_rnd);
  assign fits32  = (o64.val[63:31] == '0) || (o64.val[63:31] == '1);
  assign e32     = fits32 ? o64.val[31:0] : (o64.val[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (mac_done) begin
      case (mac_tag.dst)
        DST_M0:  m_r[0] <= acc[63:0];
        DST_M1:  m_r[1] <= acc[63:0];
        DST_M2:  m_r[2] <= acc[63:0];
        DST_DET: det_r  <= acc;
        default: ;
      endcase
    end
    if (mac_done && (mac_tag.dst == DST_OUT)) begin
      out_elem_r <= e32;
      out_idx_r  <= mac_tag.idx;
      out_last_r <= (mac_tag.idx == 4'd15);
      out_sing_r <= singular_r;
      out_sat_r  <= o64.clip | ~fits32;
    end
    if (state_r == ST_DCHK) begin
      dneg_r     <= det_r[ACC_W-1];
      singular_r <= det_zero;
      if (!div_start) begin
        r_r <= '0;   // singular or huge determinant: all outputs zero
      end
    end
    if ((state_r == ST_DIV) && div_done) begin
      r_r <= dneg_r ? -div_quo : div_quo;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    k_nxt        = k_r;
    op_nxt       = op_r;
    pc_nxt       = pc_r;
    load_cnt_nxt = load_cnt_r;
    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          load_cnt_nxt = load_cnt_r + 4'd1;
          if (load_cnt_r == 4'd15) begin
            state_nxt = ST_PF;
            phase_nxt = PH_COF;
            k_nxt     = '0;
            op_nxt    = '0;
          end
        end
      end
      ST_PF: state_nxt = ST_PS;
      ST_PS: begin
        state_nxt = ST_PM;
        pc_nxt    = '0;
      end
      ST_PM: begin
        if (!part_last) begin
          pc_nxt = pc_r + 2'd1;
        end else begin
          state_nxt = ST_PF;
          case (phase_r)
            PH_COF: begin
              if (op_r == 4'd8) begin
                op_nxt = '0;
                if (k_r == 4'd15) begin
                  phase_nxt = PH_DET;
                  k_nxt     = '0;
                end else begin
                  k_nxt = k_r + 4'd1;
                end
              end else begin
                op_nxt = op_r + 4'd1;
              end
            end
            PH_DET: begin
              if (op_r == 4'd3) begin
                state_nxt = ST_DWAIT;
              end else begin
                op_nxt = op_r + 4'd1;
              end
            end
            default: begin
              if (k_r == 4'd15) begin
                state_nxt = ST_OWAIT;
              end else begin
                k_nxt = k_r + 4'd1;
              end
            end
          endcase
        end
      end
      ST_DWAIT: begin
        if (mac_done) begin
          state_nxt = ST_DCHK;
        end
      end
      ST_DCHK: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_PF;
          phase_nxt = PH_OUT;
          k_nxt     = '0;
          op_nxt    = '0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_PF;
          phase_nxt = PH_OUT;
          k_nxt     = '0;
          op_nxt    = '0;
        end
      end
      ST_OWAIT: begin
        if (mac_done && (mac_tag.idx == 4'd15)) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      phase_r     <= PH_COF;
      k_r         <= '0;
      op_r        <= '0;
      pc_r        <= '0;
      load_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      op_r        <= op_nxt;
      pc_r        <= pc_nxt;
      load_cnt_r  <= load_cnt_nxt;
      out_valid_r <= mac_done && (mac_tag.dst == DST_OUT);
    end
  end

  assign busy            = (state_r != ST_LOAD);
  assign out_valid       = out_valid_r;
  assign out_inv_element = out_elem_r;
  assign out_index       = out_idx_r;
  assign out_last_of_run = out_last_r;
  assign out_singular    = out_sing_r;
  assign out_saturated   = out_sat_r;

  // only the final result may coincide with the return to loading
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> busy)
    else $error("result transfer while idle");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (load_cnt_r == 4'd15)) |=> busy)
    else $error("sixteenth element did not start compute");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> ((out_inv_element == 32'sd0) && !out_saturated))
    else $error("singular result not zero");

  a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r != ST_LOAD))
    else $error("accumulator result while loading");

endmodule

// ===== src/mi4_ram.sv =====
// mi4_ram: generic RAM, one write port, two registered read ports.
// Depends on nothing.
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== src/mi4_mac.sv =====
// mi4_mac: shared 32x32 multiplier with 128-bit signed accumulator.
// Depends on mi4_pkg (mac_ctl_t, tag_t).
module mi4_mac import mi4_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic [31:0]             a_part,
  input  logic [31:0]             b_part,
  output logic                    done,
  output tag_t                    done_tag,
  output logic signed [ACC_W-1:0] acc
);

  logic                    s1_vld_r;
  mac_ctl_t                s1_ctl_r;
  logic [63:0]             prod_r;
  logic                    done_r;
  tag_t                    done_tag_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0]        term;
  logic [ACC_W-1:0]        base;

  assign term = {64'd0, prod_r} << {s1_ctl_r.shift, 5'd0};
  assign base = s1_ctl_r.first ? '0 : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= ctl.issue;
      done_r   <= s1_vld_r & s1_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod_r   <= a_part * b_part;
      s1_ctl_r <= ctl;
    end
    if (s1_vld_r) begin
      acc_r      <= base + (term ^ {ACC_W{s1_ctl_r.neg}}) + ACC_W'(s1_ctl_r.neg);
      done_tag_r <= s1_ctl_r.tag;
    end
  end

  assign done     = done_r;
  assign done_tag = done_tag_r;
  assign acc      = acc_r;

endmodule

// ===== src/mi4_div.sv =====
// mi4_div: 64-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing.
module mi4_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] n_r;
  logic [63:0] den_r;
  logic [63:0] q_r;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;

  assign trial = {rem_r, n_r[63]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = ~diff[64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd63);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      n_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[63:0] : trial[63:0];
      n_r   <= {n_r[62:0], 1'b0};
      q_r   <= {q_r[62:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
